>>> hdl/spq_pkg.sv
// Shared types, codes and default sizes for the sorted priority queue.
package spq_pkg;

   localparam int DEPTH_DEF         = 16;
   localparam int VALUE_BITS_DEF    = 8;
   localparam int PRIORITY_BITS_DEF = 16;

   // Request kinds carried in req_tuser
   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_DEQUEUE = 1'b1;

   typedef enum logic [1:0] {
      STAT_ENQUEUED = 2'd0,
      STAT_DEQUEUED = 2'd1,
      STAT_EMPTY    = 2'd2,
      STAT_FULL     = 2'd3
   } status_code_type;

   // Controller to datapath
   typedef struct packed {
      logic            push;
      logic            pop;
      logic            load;
      status_code_type code;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_empty;
      logic is_full;
   } flags_type;

endpackage

>>> hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: controller, slot datapath and stream ports.
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  tuser: action; tdata: value, priority
//  rsp      out        rsp_tvalid/rsp_tready  tuser: status; tdata: value, priority, count
//
// For each transaction, all slots compare against the new key in parallel
// and the whole row shifts in the accept cycle; the result appears in the output
// register on the next cycle. One transaction per cycle is sustained while rsp_tready
// stays high. Reset (synchronous, active high) empties the queue at once; slot contents
// need no clearing. A stalled result holds, and a new request is taken in the cycle
// the held result leaves.
module sorted_priority_queue #(
   parameter int DEPTH         = spq_pkg::DEPTH_DEF,
   parameter int VALUE_BITS    = spq_pkg::VALUE_BITS_DEF,
   parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // tdata: entry_value, entry_priority, zero fill
   input  logic [((VALUE_BITS + PRIORITY_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // tuser: action
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tdata: out_value, out_priority, count, zero fill
   output logic [((VALUE_BITS + PRIORITY_BITS + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
      rsp_tdata,
   // tuser: status
   output logic [1:0] rsp_tuser
);

   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam int REQ_BITS   = ((VALUE_BITS + PRIORITY_BITS + 7) / 8) * 8;
   localparam int RSP_FIELDS = VALUE_BITS + PRIORITY_BITS + COUNT_BITS;
   localparam int RSP_BITS   = ((RSP_FIELDS + 7) / 8) * 8;

   spq_pkg::cmd_type         cmd;
   spq_pkg::flags_type       flags;
   spq_pkg::status_code_type rsp_status;
   logic [VALUE_BITS-1:0]    req_value;
   logic [PRIORITY_BITS-1:0] req_priority;
   logic [VALUE_BITS-1:0]    rsp_value;
   logic [PRIORITY_BITS-1:0] rsp_priority;
   logic [COUNT_BITS-1:0]    rsp_count;

   assign req_value    = req_tdata[VALUE_BITS-1:0];
   assign req_priority = req_tdata[VALUE_BITS + PRIORITY_BITS - 1:VALUE_BITS];

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .flags      (flags),
      .cmd        (cmd)
   );

   spq_dpath #(
      .DEPTH         (DEPTH),
      .VALUE_BITS    (VALUE_BITS),
      .PRIORITY_BITS (PRIORITY_BITS),
      .COUNT_BITS    (COUNT_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .flags        (flags),
      .req_value    (req_value),
      .req_priority (req_priority),
      .rsp_value    (rsp_value),
      .rsp_priority (rsp_priority),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count)
   );

   assign rsp_tdata = RSP_BITS'({rsp_count, rsp_priority, rsp_value});
   assign rsp_tuser = rsp_status;

   // Fill bits of the request word carry nothing
   logic unused_req_fill;
   assign unused_req_fill = (REQ_BITS > VALUE_BITS + PRIORITY_BITS) ? ^req_tdata : 1'b0;

endmodule

>>> hdl/spq_ctrl.sv
// Handshake controller: decides the operation for each transaction and tracks the held result.
module spq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_action,
   output logic              req_tready,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   input  spq_pkg::flags_type flags,
   output spq_pkg::cmd_type   cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_HOLD
   } state_type;

   state_type state_ff;
   logic      rsp_tvalid_ff;
   logic      accept;

   // Output register frees up in the same cycle its result is taken
   assign req_tready = (state_ff == ST_IDLE) || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      cmd.push = 1'b0;
      cmd.pop  = 1'b0;
      cmd.load = accept;
      cmd.code = spq_pkg::STAT_ENQUEUED;
      if (req_action == spq_pkg::ACT_ENQUEUE) begin
         if (flags.is_full) begin
            cmd.code = spq_pkg::STAT_FULL;
         end else begin
            cmd.push = accept;
            cmd.code = spq_pkg::STAT_ENQUEUED;
         end
      end else begin
         if (flags.is_empty) begin
            cmd.code = spq_pkg::STAT_EMPTY;
         end else begin
            cmd.pop  = accept;
            cmd.code = spq_pkg::STAT_DEQUEUED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff      <= ST_HOLD;
                  rsp_tvalid_ff <= 1'b1;
               end
            end
            ST_HOLD: begin
               if (accept) begin
                  state_ff      <= ST_HOLD;
                  rsp_tvalid_ff <= 1'b1;
               end else if (rsp_tready) begin
                  state_ff      <= ST_IDLE;
                  rsp_tvalid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff      <= ST_IDLE;
               rsp_tvalid_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule

>>> hdl/spq_dpath.sv
// Sorted slot row, entry count and result register.
module spq_dpath #(
   parameter int DEPTH         = spq_pkg::DEPTH_DEF,
   parameter int VALUE_BITS    = spq_pkg::VALUE_BITS_DEF,
   parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
   parameter int COUNT_BITS    = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  spq_pkg::cmd_type         cmd,
   output spq_pkg::flags_type       flags,
   input  logic [VALUE_BITS-1:0]    req_value,
   input  logic [PRIORITY_BITS-1:0] req_priority,
   output logic [VALUE_BITS-1:0]    rsp_value,
   output logic [PRIORITY_BITS-1:0] rsp_priority,
   output spq_pkg::status_code_type rsp_status,
   output logic [COUNT_BITS-1:0]    rsp_count
);

   logic [VALUE_BITS-1:0]    val_ff [DEPTH];
   logic [VALUE_BITS-1:0]    val_in [DEPTH];
   logic [PRIORITY_BITS-1:0] pri_ff [DEPTH];
   logic [PRIORITY_BITS-1:0] pri_in [DEPTH];
   logic [DEPTH-1:0]         lt;
   logic [COUNT_BITS-1:0]    count_ff;
   logic [COUNT_BITS-1:0]    count_in;

   logic [VALUE_BITS-1:0]    out_value_ff;
   logic [PRIORITY_BITS-1:0] out_priority_ff;
   spq_pkg::status_code_type out_status_ff;
   logic [COUNT_BITS-1:0]    out_count_ff;

   assign flags.is_empty = (count_ff == '0);
   assign flags.is_full  = (count_ff == COUNT_BITS'(DEPTH));

   // Each occupied slot that sorts ahead of the new key; the set is always a prefix
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         lt[i] = (COUNT_BITS'(i) < count_ff) && (pri_ff[i] < req_priority);
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_slot
      always_comb begin
         val_in[i] = val_ff[i];
         pri_in[i] = pri_ff[i];
         if (cmd.push && !lt[i]) begin
            if (i == 0) begin
               val_in[i] = req_value;
               pri_in[i] = req_priority;
            end else if (lt[(i == 0) ? 0 : i - 1]) begin
               val_in[i] = req_value;
               pri_in[i] = req_priority;
            end else begin
               // shift down to make room
               val_in[i] = val_ff[(i == 0) ? 0 : i - 1];
               pri_in[i] = pri_ff[(i == 0) ? 0 : i - 1];
            end
         end else if (cmd.pop && (i < DEPTH - 1)) begin
            val_in[i] = val_ff[(i < DEPTH - 1) ? i + 1 : i];
            pri_in[i] = pri_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end

      always_ff @(posedge clock) begin
         val_ff[i] <= val_in[i];
         pri_ff[i] <= pri_in[i];
      end
   end

   always_comb begin
      priority if (cmd.push) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Result register: zero payload unless the head is removed
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_value_ff    <= cmd.pop ? val_ff[0] : '0;
         out_priority_ff <= cmd.pop ? pri_ff[0] : '0;
         out_status_ff   <= cmd.code;
         out_count_ff    <= count_in;
      end
   end

   assign rsp_value    = out_value_ff;
   assign rsp_priority = out_priority_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_count    = out_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(DEPTH))
      else $error("entry count beyond depth");

   a_push_pop_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.pop) && !((cmd.push || cmd.pop) && !cmd.load))
      else $error("slot update without a loaded result");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      cmd.push |=> count_ff == $past(count_ff) + 1'b1)
      else $error("count did not advance on enqueue");

   a_pop_head: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |=> (out_priority_ff == $past(pri_ff[0])) && (out_value_ff == $past(val_ff[0])))
      else $error("dequeued entry is not the former head");

endmodule
